// File: sv/assert_macros.svh
// Assertion helpers for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain implication or expression, checked at every clock edge outside reset.
`define BCL_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Condition in one cycle requires another condition in the next cycle.
`define BCL_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// File: sv/bcl_pkg.sv
// ----------------------------------------------------------------------------
// bcl_pkg
// Shared types and fixed field widths of the byte-capacity LRU cache.
// ----------------------------------------------------------------------------
package bcl_pkg;

  localparam int unsigned SIZE_W = 20;
  localparam int unsigned CAP_W  = 40;
  localparam int unsigned NET_W  = 41;
  localparam int unsigned CNT_W  = 48;
  localparam int unsigned EVN_W  = 9;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVCHK,
    ST_EVRD,
    ST_EVLAT,
    ST_UNLINK,
    ST_PUSH,
    ST_FIN
  } bcl_state_e;

endpackage

// File: sv/byte_capacity_lru_cache.sv
// ----------------------------------------------------------------------------
// byte_capacity_lru_cache
// Key-value cache bounded by total bytes, with least-recently-used eviction.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_ready_o   item_key, item_size, frag_size, warmup
// out      output     out_valid_o / out_ready_i hit, stored, evicted_now, net_bytes,
//                                               bytes_in_use, hit_total
// cfg      input      cfg_we_i (no wait)        capacity_bytes
//
// A miss runs accept, key search over every slot, fit check, placement and result load;
// each eviction adds a tail read, latch and unlink, and a stale entry an unlink. A hit at the list
// head skips placement, elsewhere it is unlinked first; the scan reads one slot per cycle.
// in_ready_o is high only while the sequencer is idle; the result register lets the next
// item be accepted while a result still waits on out_ready_i, which then holds the last state.
// Reset clears the valid bits, the list pointers and all counters at once.
module byte_capacity_lru_cache #(
  parameter int unsigned ENTRIES  = 256,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bcl_pkg::CAP_W-1:0]    cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [KEY_BITS-1:0]          item_key_i,
  input  logic [bcl_pkg::SIZE_W-1:0]   item_size_i,
  input  logic [bcl_pkg::SIZE_W-1:0]   frag_size_i,
  input  logic                         warmup_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         hit_o,
  output logic                         stored_o,
  output logic [bcl_pkg::EVN_W-1:0]    evicted_now_o,
  output logic signed [bcl_pkg::NET_W-1:0] net_bytes_o,
  output logic [bcl_pkg::CAP_W-1:0]    bytes_in_use_o,
  output logic [bcl_pkg::CNT_W-1:0]    hit_total_o
);
  import bcl_pkg::*;

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Entry store: each slot holds key, sizes and its links in the recency list.
  // The list runs from head (most recent) through nxt to tail (least recent).
  logic [KEY_BITS-1:0] key_mem [ENTRIES];
  logic [SIZE_W-1:0]   size_mem[ENTRIES];
  logic [SIZE_W-1:0]   frag_mem[ENTRIES];
  logic [IW-1:0]       nxt_mem [ENTRIES];
  logic [IW-1:0]       prv_mem [ENTRIES];

  bcl_state_e state_q, state_d;

  logic [KEY_BITS-1:0] key_q, key_d;
  logic [SIZE_W-1:0]   size_q, size_d, frag_q, frag_d;
  logic                warm_q, warm_d;
  logic [IW:0]         scan_q, scan_d;
  logic                rd_ok_q, rd_ok_d;
  logic [IW-1:0]       rd_idx_q, rd_idx_d;
  logic [IW-1:0]       rd_addr;
  logic [KEY_BITS-1:0] rd_key_q;
  logic [SIZE_W-1:0]   rd_size_q, rd_frag_q;
  logic [IW-1:0]       rd_nxt_q, rd_prv_q;

  logic [IW-1:0]       ux_q, ux_d, upx_q, upx_d, unx_q, unx_d;
  logic [SIZE_W-1:0]   usz_q, usz_d;
  logic                hit_q, hit_d, stored_q, stored_d;
  logic [IW-1:0]       free_q, free_d;
  logic                free_ok_q, free_ok_d;
  logic [IW-1:0]       head_q, head_d, tail_q, tail_d;
  logic [IW:0]         count_q, count_d;
  logic [ENTRIES-1:0]  valid_q, valid_d;
  logic [CAP_W-1:0]    bytes_q, bytes_d, cap_q, cap_d;
  logic [CNT_W-1:0]    hitcnt_q, hitcnt_d;
  logic [EVN_W-1:0]    evn_q, evn_d;
  logic [NET_W-1:0]    evb_q, evb_d;

  logic                out_valid_q, out_valid_d;
  logic                out_hit_q, out_hit_d, out_stored_q, out_stored_d;
  logic [EVN_W-1:0]    out_evn_q, out_evn_d;
  logic [NET_W-1:0]    out_net_q, out_net_d;
  logic [CAP_W-1:0]    out_bytes_q, out_bytes_d;
  logic [CNT_W-1:0]    out_hitcnt_q, out_hitcnt_d;

  // Memory write controls.
  logic                ent_we;
  logic                nxt_we, prv_we;
  logic [IW-1:0]       nxt_wa, nxt_wd, prv_wa, prv_wd;

  logic                match;
  logic                fits;
  logic [NET_W-1:0]    added;

  assign in_ready_o = (state_q == ST_IDLE);
  assign rd_addr    = (state_q == ST_EVRD) ? tail_q : scan_q[IW-1:0];
  assign match      = rd_ok_q && valid_q[rd_idx_q] && (rd_key_q == key_q);
  assign fits       = ({1'b0, bytes_q} + {{(NET_W-SIZE_W){1'b0}}, size_q})
                      <= {1'b0, cap_q};
  assign added      = (stored_q && !hit_q) ? {{(NET_W-SIZE_W){1'b0}}, size_q}
                                           : '0;

  always_comb begin
    state_d      = state_q;
    key_d        = key_q;
    size_d       = size_q;
    frag_d       = frag_q;
    warm_d       = warm_q;
    scan_d       = scan_q;
    rd_ok_d      = 1'b0;
    rd_idx_d     = scan_q[IW-1:0];
    ux_d         = ux_q;
    upx_d        = upx_q;
    unx_d        = unx_q;
    usz_d        = usz_q;
    hit_d        = hit_q;
    stored_d     = stored_q;
    free_d       = free_q;
    free_ok_d    = free_ok_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    valid_d      = valid_q;
    bytes_d      = bytes_q;
    cap_d        = cfg_we_i ? cfg_wdata_i : cap_q;
    hitcnt_d     = hitcnt_q;
    evn_d        = evn_q;
    evb_d        = evb_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_hit_d    = out_hit_q;
    out_stored_d = out_stored_q;
    out_evn_d    = out_evn_q;
    out_net_d    = out_net_q;
    out_bytes_d  = out_bytes_q;
    out_hitcnt_d = out_hitcnt_q;
    ent_we       = 1'b0;
    nxt_we       = 1'b0;
    prv_we       = 1'b0;
    nxt_wa       = ux_q;
    nxt_wd       = head_q;
    prv_wa       = head_q;
    prv_wd       = free_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          key_d     = item_key_i;
          size_d    = item_size_i;
          frag_d    = frag_size_i;
          warm_d    = warmup_i;
          scan_d    = '0;
          hit_d     = 1'b0;
          stored_d  = 1'b0;
          free_ok_d = 1'b0;
          evn_d     = '0;
          evb_d     = '0;
          state_d   = ST_SCAN;
        end
      end

      // One slot is read per cycle; its compare happens in the next cycle.
      ST_SCAN: begin
        if (match) begin
          ux_d  = rd_idx_q;
          upx_d = rd_prv_q;
          unx_d = rd_nxt_q;
          usz_d = rd_size_q;
          hit_d = (rd_size_q == size_q) && (rd_frag_q == frag_q);
          if ((rd_size_q == size_q) && (rd_frag_q == frag_q) && (rd_idx_q == head_q)) begin
            stored_d = 1'b1;
            state_d  = ST_FIN;
          end else begin
            state_d = ST_UNLINK;
          end
        end else if (scan_q < (IW+1)'(ENTRIES)) begin
          rd_ok_d = 1'b1;
          scan_d  = scan_q + 1'b1;
          if (!valid_q[scan_q[IW-1:0]]) begin
            free_d    = scan_q[IW-1:0];
            free_ok_d = 1'b1;
          end
        end else if (!rd_ok_q) begin
          state_d = ST_EVCHK;
        end
      end

      ST_EVCHK: begin
        if (!fits) begin
          state_d = (count_q != '0) ? ST_EVRD : ST_FIN;
        end else if (free_ok_q) begin
          state_d = ST_PUSH;
        end else begin
          // Table full: the tail goes once more to free a slot.
          state_d = ST_EVRD;
        end
      end

      ST_EVRD: begin
        state_d = ST_EVLAT;
      end

      ST_EVLAT: begin
        ux_d    = tail_q;
        upx_d   = rd_prv_q;
        unx_d   = rd_nxt_q;
        usz_d   = rd_size_q;
        evn_d   = evn_q + 1'b1;
        evb_d   = evb_q + {{(NET_W-SIZE_W){1'b0}}, rd_size_q};
        state_d = ST_UNLINK;
      end

      // Take entry ux out of the recency list.
      ST_UNLINK: begin
        if (ux_q == head_q) begin
          head_d = unx_q;
        end else begin
          nxt_we = 1'b1;
          nxt_wa = upx_q;
          nxt_wd = unx_q;
        end
        if (ux_q == tail_q) begin
          tail_d = upx_q;
        end else begin
          prv_we = 1'b1;
          prv_wa = unx_q;
          prv_wd = upx_q;
        end
        valid_d[ux_q] = 1'b0;
        count_d       = count_q - 1'b1;
        if (!hit_q) begin
          bytes_d = bytes_q - {{(CAP_W-SIZE_W){1'b0}}, usz_q};
        end
        free_d    = ux_q;
        free_ok_d = 1'b1;
        state_d   = hit_q ? ST_PUSH : ST_EVCHK;
      end

      // Place the entry in the free slot at the front of the list.
      ST_PUSH: begin
        ent_we = 1'b1;
        if (count_q == '0) begin
          tail_d = free_q;
        end else begin
          nxt_we = 1'b1;
          nxt_wa = free_q;
          nxt_wd = head_q;
          prv_we = 1'b1;
          prv_wa = head_q;
          prv_wd = free_q;
        end
        head_d          = free_q;
        valid_d[free_q] = 1'b1;
        count_d         = count_q + 1'b1;
        if (!hit_q) begin
          bytes_d = bytes_q + {{(CAP_W-SIZE_W){1'b0}}, size_q};
        end
        stored_d = 1'b1;
        state_d  = ST_FIN;
      end

      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          if (hit_q && !warm_q) begin
            hitcnt_d = hitcnt_q + 1'b1;
          end
          out_valid_d  = 1'b1;
          out_hit_d    = hit_q;
          out_stored_d = stored_q;
          out_evn_d    = evn_q;
          out_net_d    = evb_q - added;
          out_bytes_d  = bytes_q;
          out_hitcnt_d = (hit_q && !warm_q) ? hitcnt_q + 1'b1 : hitcnt_q;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      scan_q       <= '0;
      rd_ok_q      <= 1'b0;
      hit_q        <= 1'b0;
      stored_q     <= 1'b0;
      free_ok_q    <= 1'b0;
      head_q       <= '0;
      tail_q       <= '0;
      count_q      <= '0;
      valid_q      <= '0;
      bytes_q      <= '0;
      cap_q        <= '0;
      hitcnt_q     <= '0;
      evn_q        <= '0;
      evb_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      scan_q       <= scan_d;
      rd_ok_q      <= rd_ok_d;
      hit_q        <= hit_d;
      stored_q     <= stored_d;
      free_ok_q    <= free_ok_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      count_q      <= count_d;
      valid_q      <= valid_d;
      bytes_q      <= bytes_d;
      cap_q        <= cap_d;
      hitcnt_q     <= hitcnt_d;
      evn_q        <= evn_d;
      evb_q        <= evb_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers and the entry memories.
  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    size_q       <= size_d;
    frag_q       <= frag_d;
    warm_q       <= warm_d;
    rd_idx_q     <= rd_idx_d;
    ux_q         <= ux_d;
    upx_q        <= upx_d;
    unx_q        <= unx_d;
    usz_q        <= usz_d;
    free_q       <= free_d;
    out_hit_q    <= out_hit_d;
    out_stored_q <= out_stored_d;
    out_evn_q    <= out_evn_d;
    out_net_q    <= out_net_d;
    out_bytes_q  <= out_bytes_d;
    out_hitcnt_q <= out_hitcnt_d;
    if (ent_we) begin
      key_mem[free_q]  <= key_q;
      size_mem[free_q] <= size_q;
      frag_mem[free_q] <= frag_q;
    end
    if (nxt_we) begin
      nxt_mem[nxt_wa] <= nxt_wd;
    end
    if (prv_we) begin
      prv_mem[prv_wa] <= prv_wd;
    end
    rd_key_q  <= key_mem[rd_addr];
    rd_size_q <= size_mem[rd_addr];
    rd_frag_q <= frag_mem[rd_addr];
    rd_nxt_q  <= nxt_mem[rd_addr];
    rd_prv_q  <= prv_mem[rd_addr];
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = out_hit_q;
  assign stored_o       = out_stored_q;
  assign evicted_now_o  = out_evn_q;
  assign net_bytes_o    = out_net_q;
  assign bytes_in_use_o = out_bytes_q;
  assign hit_total_o    = out_hitcnt_q;

endmodule

// File: sv/bcl_checker.sv
// ----------------------------------------------------------------------------
// bcl_checker
// Port-level checks of the byte-capacity LRU cache, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bcl_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic                           hit_o,
  input logic                           stored_o,
  input logic [bcl_pkg::EVN_W-1:0]      evicted_now_o,
  input logic signed [bcl_pkg::NET_W-1:0] net_bytes_o
);
  import bcl_pkg::*;

  // A result that is not taken stays offered.
  `BCL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)

  // A hit always leaves the item resident.
  `BCL_ASSERT(a_hit_stored, clk_i, rst_ni, (out_valid_o && hit_o) |-> stored_o)

  // A hit neither evicts nor changes the byte count.
  `BCL_ASSERT(a_hit_quiet, clk_i, rst_ni, (out_valid_o && hit_o) |-> (evicted_now_o == '0 && net_bytes_o == '0))

  // The sequencer leaves idle to search, so the input side closes after an item.
  `BCL_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

endmodule

bind byte_capacity_lru_cache bcl_checker u_bcl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .hit_o         (hit_o),
  .stored_o      (stored_o),
  .evicted_now_o (evicted_now_o),
  .net_bytes_o   (net_bytes_o)
);
